@@ rtl/md5_pkg.sv @@
// Shared types and constants of the MD5 digest block.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Per-round additive constants
    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {round group, round[1:0]}
    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Index 0 = A ... 3 = D
    typedef logic [3:0][31:0] md5_words_t;

    typedef struct packed {
        logic start;    // load work from chain and run 64 rounds
        logic init;     // reload the chain with the initial value
    } md5_ctl_t;

endpackage
`default_nettype wire

@@ rtl/md5_byte_if.sv @@
// Message byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface md5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/md5_digest_if.sv @@
// Digest byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface md5_digest_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_end;

    modport source (output valid, output digest_byte, output digest_end, input ready);
    modport sink (input valid, input digest_byte, input digest_end, output ready);
endinterface
`default_nettype wire

@@ rtl/md5_round.sv @@
// One MD5 round: boolean function, four-operand add, rotate and final add.
`timescale 1ns / 1ps
`default_nettype none
module md5_round
    import md5_pkg::*;
(
    input  wire logic [5:0]  round,
    input  wire md5_words_t  work,
    input  wire logic [31:0] m_word,
    output logic [3:0]       m_index,
    output md5_words_t       work_next
);

    logic [31:0] a, b, c, d;
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  rot;
    logic [63:0] rot_wide;
    logic [3:0]  r4;

    assign a  = work[0];
    assign b  = work[1];
    assign c  = work[2];
    assign d  = work[3];
    assign r4 = round[3:0];

    always_comb
    begin
        unique case (round[5:4])
            2'd0:
            begin
                f       = (b & c) | (~b & d);
                m_index = r4;
            end
            2'd1:
            begin
                f       = (b & d) | (c & ~d);
                m_index = {r4[1:0], 2'b00} + r4 + 4'd1;
            end
            2'd2:
            begin
                f       = b ^ c ^ d;
                m_index = {r4[2:0], 1'b0} + r4 + 4'd5;
            end
            default:
            begin
                f       = c ^ (b | ~d);
                m_index = {r4[0], 3'b000} - r4;
            end
        endcase
    end

    assign sum      = a + f + K_TABLE[round] + m_word;
    assign rot      = ROT_TABLE[{round[5:4], round[1:0]}];
    assign rot_wide = {sum, sum} << rot;

    assign work_next[0] = d;
    assign work_next[1] = b + rot_wide[63:32];
    assign work_next[2] = b;
    assign work_next[3] = c;

endmodule
`default_nettype wire

@@ rtl/md5_compress.sv @@
// Block compression: round counter, working registers and chaining value.
`timescale 1ns / 1ps
`default_nettype none
module md5_compress
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire md5_ctl_t    ctl,
    input  wire logic [31:0] m_word,
    output logic [3:0]       m_index,
    output logic             done,
    output md5_words_t       chain
);

    md5_words_t chain_reg;
    md5_words_t work_reg;
    md5_words_t work_next;
    logic [5:0] round_reg;
    logic       busy_reg;
    logic       fold_reg;

    md5_round u_round (
        .round     (round_reg),
        .work      (work_reg),
        .m_word    (m_word),
        .m_index   (m_index),
        .work_next (work_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= {IV_D, IV_C, IV_B, IV_A};
            busy_reg  <= 1'b0;
            fold_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            fold_reg <= 1'b0;
            if (ctl.init)
            begin
                chain_reg <= {IV_D, IV_C, IV_B, IV_A};
            end
            else if (fold_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (ctl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            work_reg <= chain_reg;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
        end
    end

    // done is high in the cycle the chain takes the sum
    assign done  = fold_reg;
    assign chain = chain_reg;

endmodule
`default_nettype wire

@@ rtl/md5_message_digest_top.sv @@
// MD5 digest block: byte packing, padding sequencer and digest output.
//
// Usage: message bytes arrive on msg (data_byte, last_byte) with valid/ready;
// the digest leaves on digest as 16 bytes, A..D, each word low byte first,
// with digest_end on the sixteenth. A request is taken when valid and ready
// are both high.
// Flow: a byte that does not complete a 64-byte block is taken while ready
// stays high. A byte that completes a block holds ready low for 64 rounds
// through the single round unit, one round per cycle, and the chain add.
// After the last byte, the padding state lays out the 0x80 byte and zeros;
// each padded block then runs the rounds (one block, or two when fewer than
// 9 bytes of room remain, the length state laying out the second), then 16
// digest bytes leave at one per cycle while the receiver is ready.
// Reset: chain value to the MD5 initial words, bit count to zero; the word
// buffer holds no defined contents until bytes are written.
// A stalled receiver holds the current digest byte; msg stays not ready until
// all 16 bytes are taken, then the next message starts from the initial value.
`timescale 1ns / 1ps
`default_nettype none
module md5_message_digest_top
    import md5_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    md5_byte_if.sink      msg,
    md5_digest_if.source  digest
);

    localparam logic [3:0] ST_FILL      = 4'd0;
    localparam logic [3:0] ST_WAIT_FILL = 4'd1;
    localparam logic [3:0] ST_WAIT_PAD  = 4'd2;
    localparam logic [3:0] ST_PAD       = 4'd3;
    localparam logic [3:0] ST_WAIT_LEN  = 4'd4;
    localparam logic [3:0] ST_LEN       = 4'd5;
    localparam logic [3:0] ST_WAIT_OUT  = 4'd6;
    localparam logic [3:0] ST_OUT       = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [63:0] bit_count_reg;
    logic [3:0]  out_idx_reg;
    logic [31:0] words_reg [16];
    logic [31:0] pad_word [16];

    logic [5:0]  pos;
    logic        in_accept;
    logic        out_accept;
    logic        out_last;
    logic        room_for_len;
    md5_ctl_t    ctl;
    logic [3:0]  m_index;
    logic        done;
    md5_words_t  chain;

    md5_compress u_compress (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .m_word  (words_reg[m_index]),
        .m_index (m_index),
        .done    (done),
        .chain   (chain)
    );

    assign pos          = bit_count_reg[8:3];
    assign room_for_len = (pos < 6'd56);
    assign msg.ready    = (state_reg == ST_FILL);
    assign in_accept    = msg.valid && msg.ready;

    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_byte = chain[out_idx_reg[3:2]][{out_idx_reg[1:0], 3'b000} +: 8];
    assign digest.digest_end  = out_last;
    assign out_last           = (out_idx_reg == 4'd15);
    assign out_accept         = digest.valid && digest.ready;

    assign ctl.start = (in_accept && (pos == 6'd63)) || (state_reg == ST_PAD)
                       || (state_reg == ST_LEN);
    assign ctl.init  = out_accept && out_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_accept)
                begin
                    if (pos == 6'd63)
                    begin
                        state_next = msg.last_byte ? ST_WAIT_PAD : ST_WAIT_FILL;
                    end
                    else if (msg.last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_WAIT_FILL:
            begin
                if (done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_WAIT_PAD:
            begin
                if (done)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                state_next = room_for_len ? ST_WAIT_OUT : ST_WAIT_LEN;
            end
            ST_WAIT_LEN:
            begin
                if (done)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_WAIT_OUT;
            end
            ST_WAIT_OUT:
            begin
                if (done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_accept && out_last)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            bit_count_reg <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
            end
            else if (out_accept && out_last)
            begin
                bit_count_reg <= '0;
            end
            if (out_accept)
            begin
                out_idx_reg <= out_idx_reg + 4'd1;
            end
        end
    end

    // 0x80 at the next free byte, zeros above it; length words when they fit
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            pad_word[w] = words_reg[w];
            for (int j = 0; j < 4; j++)
            begin
                if ((4'(w) > pos[5:2]) || ((4'(w) == pos[5:2]) && (2'(j) > pos[1:0])))
                begin
                    pad_word[w][8*j +: 8] = 8'h00;
                end
                else if ((4'(w) == pos[5:2]) && (2'(j) == pos[1:0]))
                begin
                    pad_word[w][8*j +: 8] = 8'h80;
                end
            end
        end
        if (room_for_len)
        begin
            pad_word[14] = bit_count_reg[31:0];
            pad_word[15] = bit_count_reg[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_accept)
                begin
                    if (pos[1:0] == 2'd0)
                    begin
                        words_reg[pos[5:2]] <= {24'd0, msg.data_byte};
                    end
                    else
                    begin
                        words_reg[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= msg.data_byte;
                    end
                end
            end
            ST_PAD:
            begin
                for (int w = 0; w < 16; w++)
                begin
                    words_reg[w] <= pad_word[w];
                end
            end
            ST_LEN:
            begin
                for (int w = 0; w < 14; w++)
                begin
                    words_reg[w] <= '0;
                end
                words_reg[14] <= bit_count_reg[31:0];
                words_reg[15] <= bit_count_reg[63:32];
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire
